### design/csp_pkg.sv
// Shared types and constants for the byte stack with rotate.
package csp_pkg;

   localparam int RESULT_LIMIT = 64;
   localparam int OCC_W        = 7;
   localparam int CAP_W        = 7;
   localparam int BYTE_W       = 8;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // word-address bit of the register file; capacity is the only register
   localparam logic REG_CAPACITY = 1'b0;

   // request codes
   localparam logic [2:0] OP_PUSH  = 3'd0;
   localparam logic [2:0] OP_POP   = 3'd1;
   localparam logic [2:0] OP_PEEK  = 3'd2;
   localparam logic [2:0] OP_DUP   = 3'd3;
   localparam logic [2:0] OP_ROTUP = 3'd4;
   localparam logic [2:0] OP_ROTDN = 3'd5;
   localparam logic [2:0] OP_PRINT = 3'd6;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_NOOP  = 2'd3;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [BYTE_W-1:0] push_value;
      logic [6:0]        rotate_count;
   } request_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [BYTE_W-1:0] element;
      logic              element_valid;
      logic              last;
   } response_type;

endpackage

### design/char_stack_with_rotate_core.sv
// Bounded byte stack with dup, two rotations and print, run by a small sequencer.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  csp_pkg::request_type
//   rsp       out        rsp_valid / rsp_stall  csp_pkg::response_type
//   csr       in/out     psel/penable/pready    capacity at byte address 0
//
// Push and pop finish in idle, peek and dup read the top byte first, a
// rotation saves the wrap byte, shifts the rest, writes it back, and print
// reads bytewise, as the single registered read port moves one byte per cycle.
// Reset empties the stack and sets capacity to 64; memory contents are not
// cleared. A new request is taken only while the sequencer is idle and the
// result register is empty or being taken; rsp_stall pauses print per byte.
module char_stack_with_rotate_core #(
   parameter int DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  csp_pkg::request_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output csp_pkg::response_type          rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [csp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [csp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [csp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int STORE_DEPTH = (DEPTH < csp_pkg::RESULT_LIMIT) ? DEPTH : csp_pkg::RESULT_LIMIT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam logic [csp_pkg::OCC_W-1:0] STORE_MAX = csp_pkg::OCC_W'(STORE_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PEEK  = 3'd1;
   localparam logic [2:0] S_DUP   = 3'd2;
   localparam logic [2:0] S_SAVE  = 3'd3;
   localparam logic [2:0] S_MOVE  = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_PRINT = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [csp_pkg::OCC_W-1:0]    occ_ff, occ_in;
   logic [csp_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic [ADDR_W-1:0]            src_ff, src_in;
   logic [ADDR_W-1:0]            dst_ff, dst_in;
   logic [ADDR_W-1:0]            end_ff, end_in;
   logic                         down_ff, down_in;
   logic [csp_pkg::BYTE_W-1:0]   tmp_ff, tmp_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   csp_pkg::response_type        rsp_data_ff, rsp_data_in;

   logic                         ram_we, ram_re;
   logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
   logic [csp_pkg::BYTE_W-1:0]   ram_wdata, ram_rdata;

   logic                         out_free, accept, csr_write;
   logic [csp_pkg::OCC_W-1:0]    lim, occ_m1, lo_full;
   logic [ADDR_W-1:0]            src_step;
   logic                         empty, full;

   csp_stack_ram #(
      .ENTRIES (STORE_DEPTH),
      .ADDR_W  (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == csp_pkg::REG_CAPACITY);
   assign prdata    = (paddr[2] == csp_pkg::REG_CAPACITY) ?
                      {{(csp_pkg::CSR_DATA_W-csp_pkg::CAP_W){1'b0}}, cap_ff} : '0;
   assign cap_in    = csr_write ? pwdata[csp_pkg::CAP_W-1:0] : cap_ff;

   assign lim     = (cap_ff > STORE_MAX) ? STORE_MAX : cap_ff;
   assign occ_m1  = occ_ff - 1'b1;
   assign lo_full = occ_ff - req_data.rotate_count;
   assign empty   = (occ_ff == '0);
   assign full    = (occ_ff >= lim);

   // shared index step: down_ff walks toward the top, else toward the bottom
   assign src_step = down_ff ? src_ff + 1'b1 : src_ff - 1'b1;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      end_in       = end_ff;
      down_in      = down_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = src_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = src_step;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_data_in.status        = csp_pkg::ST_OK;
               rsp_data_in.element       = '0;
               rsp_data_in.element_valid = 1'b0;
               rsp_data_in.last          = 1'b1;
               rsp_valid_in              = 1'b1;
               case (req_data.req_type)
                  csp_pkg::OP_PUSH: begin
                     if (full) begin
                        rsp_data_in.status = csp_pkg::ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = occ_ff[ADDR_W-1:0];
                        ram_wdata = req_data.push_value;
                        occ_in    = occ_ff + 1'b1;
                     end
                  end
                  csp_pkg::OP_POP: begin
                     if (empty) begin
                        rsp_data_in.status = csp_pkg::ST_EMPTY;
                     end else begin
                        occ_in = occ_m1;
                     end
                  end
                  csp_pkg::OP_PEEK: begin
                     if (empty) begin
                        rsp_data_in.status = csp_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        ram_raddr    = occ_m1[ADDR_W-1:0];
                        state_in     = S_PEEK;
                     end
                  end
                  csp_pkg::OP_DUP: begin
                     if (empty) begin
                        rsp_data_in.status = csp_pkg::ST_EMPTY;
                     end else if (full) begin
                        rsp_data_in.status = csp_pkg::ST_FULL;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        ram_raddr    = occ_m1[ADDR_W-1:0];
                        state_in     = S_DUP;
                     end
                  end
                  csp_pkg::OP_ROTUP: begin
                     if (req_data.rotate_count > occ_ff) begin
                        rsp_data_in.status = csp_pkg::ST_NOOP;
                     end else if (req_data.rotate_count >= 7'd2) begin
                        rsp_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        ram_raddr    = occ_m1[ADDR_W-1:0];
                        src_in       = occ_m1[ADDR_W-1:0];
                        end_in       = lo_full[ADDR_W-1:0];
                        down_in      = 1'b0;
                        state_in     = S_SAVE;
                     end
                  end
                  csp_pkg::OP_ROTDN: begin
                     if (req_data.rotate_count > occ_ff || req_data.rotate_count < 7'd2) begin
                        rsp_data_in.status = csp_pkg::ST_NOOP;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        ram_raddr    = lo_full[ADDR_W-1:0];
                        src_in       = lo_full[ADDR_W-1:0];
                        end_in       = occ_m1[ADDR_W-1:0];
                        down_in      = 1'b1;
                        state_in     = S_SAVE;
                     end
                  end
                  csp_pkg::OP_PRINT: begin
                     if (!empty) begin
                        rsp_valid_in = 1'b0;
                        ram_re       = 1'b1;
                        ram_raddr    = occ_m1[ADDR_W-1:0];
                        src_in       = occ_m1[ADDR_W-1:0];
                        end_in       = '0;
                        down_in      = 1'b0;
                        state_in     = S_PRINT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PEEK: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = csp_pkg::ST_OK;
               rsp_data_in.element       = ram_rdata;
               rsp_data_in.element_valid = 1'b1;
               rsp_data_in.last          = 1'b1;
               state_in                  = S_IDLE;
            end
         end
         S_DUP: begin
            if (out_free) begin
               ram_we                    = 1'b1;
               ram_waddr                 = occ_ff[ADDR_W-1:0];
               ram_wdata                 = ram_rdata;
               occ_in                    = occ_ff + 1'b1;
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = csp_pkg::ST_OK;
               rsp_data_in.element       = '0;
               rsp_data_in.element_valid = 1'b0;
               rsp_data_in.last          = 1'b1;
               state_in                  = S_IDLE;
            end
         end
         S_SAVE: begin
            // hold the byte that wraps around, start fetching the next source
            tmp_in   = ram_rdata;
            dst_in   = src_ff;
            src_in   = src_step;
            ram_re   = 1'b1;
            ram_raddr = src_step;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            ram_we    = 1'b1;
            ram_waddr = dst_ff;
            ram_wdata = ram_rdata;
            if (src_ff == end_ff) begin
               state_in = S_FIN;
            end else begin
               dst_in    = src_ff;
               src_in    = src_step;
               ram_re    = 1'b1;
               ram_raddr = src_step;
            end
         end
         S_FIN: begin
            if (out_free) begin
               ram_we                    = 1'b1;
               ram_waddr                 = src_ff;
               ram_wdata                 = tmp_ff;
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = csp_pkg::ST_OK;
               rsp_data_in.element       = '0;
               rsp_data_in.element_valid = 1'b0;
               rsp_data_in.last          = 1'b1;
               state_in                  = S_IDLE;
            end
         end
         S_PRINT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = csp_pkg::ST_OK;
               rsp_data_in.element       = ram_rdata;
               rsp_data_in.element_valid = 1'b1;
               rsp_data_in.last          = (src_ff == end_ff);
               if (src_ff == end_ff) begin
                  state_in = S_IDLE;
               end else begin
                  src_in    = src_step;
                  ram_re    = 1'b1;
                  ram_raddr = src_step;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         cap_ff       <= csp_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      end_ff      <= end_in;
      down_ff     <= down_in;
      tmp_ff      <= tmp_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### design/csp_stack_ram.sv
// Stack storage: one write port, one read port with registered read data.
module csp_stack_ram #(
   parameter int ENTRIES = 64,
   parameter int ADDR_W  = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [csp_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [csp_pkg::BYTE_W-1:0] rd_data
);

   logic [csp_pkg::BYTE_W-1:0] mem_ff [ENTRIES];
   logic [csp_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
